FILE: hw/rtl/vhs_pkg.sv
// ----------------------------------------------------------------------------
// vhs_pkg
// Shared types and constants of the vorticity and helicity stencil.
// ----------------------------------------------------------------------------
package vhs_pkg;

  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] REG_SIZE_X = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SIZE_Y = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SIZE_Z = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_COEF_X = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_COEF_Y = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_COEF_Z = 3'd5;

  localparam logic [6:0]  SIZE_XY_RST = 7'd64;
  localparam logic [11:0] SIZE_Z_RST  = 12'd64;
  localparam logic [15:0] COEF_RST    = 16'd1280;

  // Steps of the datapath sequence
  localparam logic [4:0] RD_LAST   = 5'd6;
  localparam logic [4:0] MUL_LAST  = 5'd12;
  localparam logic [4:0] SQRT_LAST = 5'd31;

  typedef struct packed {
    logic [6:0]  size_x;
    logic [6:0]  size_y;
    logic [11:0] size_z;
    logic [15:0] coef_x;
    logic [15:0] coef_y;
    logic [15:0] coef_z;
  } cfg_t;

  typedef struct packed {
    logic       load;      // take the input item, advance position
    logic       rd;        // issue a plane read
    logic       wr;        // write the voxel into its plane
    logic       mul;       // multiply/accumulate step
    logic       sq_init;   // start the square root
    logic       sq_step;   // one square-root iteration
    logic       out_load;  // move the result into the output register
    logic [4:0] step;
  } cmd_t;

  typedef struct packed {
    logic interior;
    logic out_busy;
  } sts_t;

endpackage

FILE: hw/rtl/vhs_ctrl.sv
// ----------------------------------------------------------------------------
// vhs_ctrl
// Sequencer: read stencil, multiply chain, square root, hand off result.
// ----------------------------------------------------------------------------
module vhs_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  input  vhs_pkg::sts_t sts,
  output vhs_pkg::cmd_t cmd
);

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_RD   = 5'b00010,
    S_MUL  = 5'b00100,
    S_SQRT = 5'b01000,
    S_DONE = 5'b10000
  } state_t;

  state_t     state, state_next;
  logic [4:0] cnt, cnt_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      cnt   <= '0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
    end
  end

  always_comb begin
    state_next = state;
    cnt_next   = cnt + 5'd1;
    in_ready   = 1'b0;
    cmd        = '0;
    cmd.step   = cnt;
    unique case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        cnt_next = '0;
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = S_RD;
        end
      end
      S_RD: begin
        cmd.rd = (cnt != vhs_pkg::RD_LAST);
        cmd.wr = (cnt == vhs_pkg::RD_LAST);
        if (cnt == vhs_pkg::RD_LAST) begin
          cnt_next   = '0;
          state_next = sts.interior ? S_MUL : S_IDLE;
        end
      end
      S_MUL: begin
        cmd.mul = 1'b1;
        if (cnt == vhs_pkg::MUL_LAST) begin
          cmd.sq_init = 1'b1;
          cnt_next    = '0;
          state_next  = S_SQRT;
        end
      end
      S_SQRT: begin
        cmd.sq_step = 1'b1;
        if (cnt == vhs_pkg::SQRT_LAST) begin
          cnt_next   = '0;
          state_next = S_DONE;
        end
      end
      S_DONE: begin
        cnt_next = '0;
        if (!sts.out_busy) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

FILE: hw/rtl/vhs_datapath.sv
// ----------------------------------------------------------------------------
// vhs_datapath
// Position counters, plane memory, shared multiplier, square root, output.
// ----------------------------------------------------------------------------
module vhs_datapath #(
  parameter int MAX_X    = 64,
  parameter int MAX_Y    = 64,
  parameter int VEL_BITS = 16
) (
  input  logic                clk,
  input  logic                rst,
  input  vhs_pkg::cfg_t       cfg,
  input  vhs_pkg::cmd_t       cmd,
  output vhs_pkg::sts_t       sts,
  input  logic signed [15:0]  vel_x,
  input  logic signed [15:0]  vel_y,
  input  logic signed [15:0]  vel_z,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [5:0]          pos_x,
  output logic [5:0]          pos_y,
  output logic [11:0]         pos_z,
  output logic signed [31:0]  curl_x,
  output logic signed [31:0]  curl_y,
  output logic signed [31:0]  curl_z,
  output logic [31:0]         curl_magnitude,
  output logic signed [47:0]  helicity,
  output logic                last_voxel
);

  localparam int VB    = VEL_BITS;
  localparam int WW    = 3 * VB;
  localparam int XW    = $clog2(MAX_X);
  localparam int YW    = $clog2(MAX_Y);
  localparam int XS    = $clog2(MAX_X + 1);
  localparam int YS    = $clog2(MAX_Y + 1);
  localparam int XC    = XS + 1;
  localparam int YC    = YS + 1;
  localparam int PW    = MAX_X * MAX_Y;
  localparam int DEPTH = 2 * PW;
  localparam int AW    = $clog2(DEPTH);
  localparam int EW    = (VB > 16) ? VB : 16;

  function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
    if (v > 66'sh7FFF_FFFF) return 32'sh7FFF_FFFF;
    else if (v < -66'sh8000_0000) return 32'sh8000_0000;
    else return v[31:0];
  endfunction

  function automatic logic signed [47:0] sat48(input logic signed [65:0] v);
    if (v > 66'sh7FFF_FFFF_FFFF) return 48'sh7FFF_FFFF_FFFF;
    else if (v < -66'sh8000_0000_0000) return 48'sh8000_0000_0000;
    else return v[47:0];
  endfunction

  // Sizes in use
  logic [XS-1:0] sx;
  logic [YS-1:0] sy;
  logic [11:0]   sz;

  always_comb begin
    if (cfg.size_x < 7'd3) sx = XS'(3);
    else if (int'(cfg.size_x) > MAX_X) sx = XS'(MAX_X);
    else sx = XS'(cfg.size_x);
    if (cfg.size_y < 7'd3) sy = YS'(3);
    else if (int'(cfg.size_y) > MAX_Y) sy = YS'(MAX_Y);
    else sy = YS'(cfg.size_y);
    sz = (cfg.size_z < 12'd3) ? 12'd3 : cfg.size_z;
  end

  // Position of the next voxel
  logic [XW-1:0] col;
  logic [YW-1:0] row;
  logic [11:0]   pl;
  logic [XS-1:0] col_inc;
  logic [YS-1:0] row_inc;
  logic [12:0]   pl_inc;
  logic          at_interior, at_last;

  assign col_inc = XS'(col) + XS'(1);
  assign row_inc = YS'(row) + YS'(1);
  assign pl_inc  = 13'(pl) + 13'd1;

  assign at_interior = (pl >= 12'd2) && (pl < sz) && (col != '0) && (row != '0) &&
                       (XC'(col) + XC'(2) <= XC'(sx)) && (YC'(row) + YC'(2) <= YC'(sy));
  assign at_last = (XC'(col) + XC'(2) == XC'(sx)) && (YC'(row) + YC'(2) == YC'(sy)) &&
                   (pl_inc == 13'(sz));

  always_ff @(posedge clk) begin
    if (rst) begin
      col <= '0;
      row <= '0;
      pl  <= '0;
    end else if (cmd.load) begin
      if (col_inc >= sx) begin
        col <= '0;
        if (row_inc >= sy) begin
          row <= '0;
          pl  <= (pl_inc >= 13'(sz)) ? 12'd0 : pl_inc[11:0];
        end else begin
          row <= YW'(row_inc);
        end
      end else begin
        col <= XW'(col_inc);
      end
    end
  end

  // Latched item
  logic [XW-1:0] px;
  logic [YW-1:0] py;
  logic [11:0]   pz;
  logic          interior, last_q;
  logic [WW-1:0] vin_w;

  always_ff @(posedge clk) begin
    if (rst) begin
      interior <= 1'b0;
    end else if (cmd.load) begin
      interior <= at_interior;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      px     <= col;
      py     <= row;
      pz     <= pl;
      last_q <= at_last;
      vin_w  <= {VB'(EW'($unsigned(vel_z))), VB'(EW'($unsigned(vel_y))),
                 VB'(EW'($unsigned(vel_x)))};
    end
  end

  assign sts.interior = interior;
  assign sts.out_busy = out_valid && !out_ready;

  // Plane memory, two planes by parity
  logic [WW-1:0] mem [DEPTH];
  logic [WW-1:0] rdata;
  logic [AW-1:0] raddr, waddr;
  logic [XW-1:0] rx;
  logic [YW-1:0] ry;
  logic          rpar;

  always_comb begin
    rx   = px;
    ry   = py;
    rpar = ~pz[0];
    unique case (cmd.step)
      5'd0: rx = px + XW'(1);
      5'd1: rx = px - XW'(1);
      5'd2: ry = py + YW'(1);
      5'd3: ry = py - YW'(1);
      5'd4: rpar = ~pz[0];
      5'd5: rpar = pz[0];
      default: rpar = ~pz[0];
    endcase
  end

  assign raddr = AW'(rpar) * AW'(PW) + AW'(ry) * AW'(MAX_X) + AW'(rx);
  assign waddr = AW'(pz[0]) * AW'(PW) + AW'(py) * AW'(MAX_X) + AW'(px);

  always_ff @(posedge clk) begin
    if (cmd.wr) begin
      mem[waddr] <= vin_w;
    end
    rdata <= mem[raddr];
  end

  // Stencil neighbors: +x, -x, +y, -y, center, previous-plane center
  logic [WW-1:0] nb [6];
  logic [2:0]    cap_idx;

  assign cap_idx = 3'(cmd.step - 5'd1);

  always_ff @(posedge clk) begin
    if ((cmd.rd || cmd.wr) && cmd.step != 5'd0) begin
      nb[cap_idx] <= rdata;
    end
  end

  logic signed [VB-1:0] nv [6][3];
  logic signed [VB-1:0] vv [3];
  logic signed [VB:0]   dx [3];
  logic signed [VB:0]   dy [3];
  logic signed [VB:0]   dz [3];

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      for (int k = 0; k < 6; k++) begin
        nv[k][c] = nb[k][c*VB +: VB];
      end
      vv[c] = vin_w[c*VB +: VB];
      dx[c] = (VB+1)'(nv[0][c]) - (VB+1)'(nv[1][c]);
      dy[c] = (VB+1)'(nv[2][c]) - (VB+1)'(nv[3][c]);
      dz[c] = (VB+1)'(vv[c]) - (VB+1)'(nv[5][c]);
    end
  end

  // Shared multiplier: issue op at step s, consume its product at step s+1
  logic signed [32:0] op_a, op_b;
  logic signed [65:0] prod, t_acc, h_acc, diffw;
  logic signed [31:0] w0, w1, w2;
  logic [63:0]        sq, r_sq, bitv, tmp;

  always_comb begin
    op_a = 33'(w0);
    op_b = 33'(w0);
    unique case (cmd.step)
      5'd0:  begin op_a = 33'(dy[2]); op_b = 33'(cfg.coef_y); end
      5'd1:  begin op_a = 33'(dz[1]); op_b = 33'(cfg.coef_z); end
      5'd2:  begin op_a = 33'(dz[0]); op_b = 33'(cfg.coef_z); end
      5'd3:  begin op_a = 33'(dx[2]); op_b = 33'(cfg.coef_x); end
      5'd4:  begin op_a = 33'(dx[1]); op_b = 33'(cfg.coef_x); end
      5'd5:  begin op_a = 33'(dy[0]); op_b = 33'(cfg.coef_y); end
      5'd6:  begin op_a = 33'(w0);    op_b = 33'(w0); end
      5'd7:  begin op_a = 33'(w1);    op_b = 33'(w1); end
      5'd8:  begin op_a = 33'(w2);    op_b = 33'(w2); end
      5'd9:  begin op_a = 33'(nv[4][0]); op_b = 33'(w0); end
      5'd10: begin op_a = 33'(nv[4][1]); op_b = 33'(w1); end
      5'd11: begin op_a = 33'(nv[4][2]); op_b = 33'(w2); end
      default: begin op_a = 33'(w0); op_b = 33'(w0); end
    endcase
  end

  assign diffw = (t_acc - prod) >>> 8;
  assign tmp   = r_sq + bitv;

  always_ff @(posedge clk) begin
    prod <= op_a * op_b;
    if (cmd.mul) begin
      unique case (cmd.step)
        5'd1, 5'd3, 5'd5: t_acc <= prod;
        5'd2:             w0 <= sat32(diffw);
        5'd4:             w1 <= sat32(diffw);
        5'd6:             w2 <= sat32(diffw);
        5'd7:             sq <= prod[63:0];
        5'd8, 5'd9:       sq <= sq + prod[63:0];
        5'd10:            h_acc <= prod;
        5'd11, 5'd12:     h_acc <= h_acc + prod;
        default:          t_acc <= t_acc;
      endcase
    end
    if (cmd.sq_init) begin
      r_sq <= '0;
      bitv <= 64'h4000_0000_0000_0000;
    end else if (cmd.sq_step) begin
      if (sq >= tmp) begin
        sq   <= sq - tmp;
        r_sq <= (r_sq >> 1) + bitv;
      end else begin
        r_sq <= r_sq >> 1;
      end
      bitv <= bitv >> 2;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      pos_x          <= 6'(px);
      pos_y          <= 6'(py);
      pos_z          <= pz - 12'd1;
      curl_x         <= w0;
      curl_y         <= w1;
      curl_z         <= w2;
      curl_magnitude <= (r_sq > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : r_sq[31:0];
      helicity       <= sat48(h_acc >>> 8);
      last_voxel     <= last_q;
    end
  end

`ifndef SYNTH
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |-> (!out_valid || out_ready))
    else $error("result loaded over a pending result");
  a_wr_alone: assert property (@(posedge clk) disable iff (rst)
    cmd.wr |-> (!cmd.rd && !cmd.mul))
    else $error("plane write overlaps a read or multiply step");
  a_out_source: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(cmd.out_load))
    else $error("output valid without a load");
`endif

endmodule

FILE: hw/rtl/vorticity_helicity_stencil.sv
// ----------------------------------------------------------------------------
// vorticity_helicity_stencil
// Streaming central-difference curl, curl magnitude and helicity of a volume.
// ----------------------------------------------------------------------------
// Voxels arrive in raster order (x fastest, then y, then z) as signed velocity
// triples. The block keeps the two previous planes in a plane memory with one
// read and one write port; when voxel (x,y,z+1) arrives it reports curl, integer
// magnitude and helicity for the interior voxel (x,y,z). Border voxels give no
// result. Each item is accepted, then takes six neighbor reads and one write of
// the memory; an item that yields a result adds the multiply steps on the one
// shared 33x33 multiplier, the bit-per-cycle square root and the load of the
// output register.
// The output register holds a finished item while the next one is taken.
// Write configuration only while the block is idle.
module vorticity_helicity_stencil #(
  parameter int MAX_X    = 64,
  parameter int MAX_Y    = 64,
  parameter int VEL_BITS = 16
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [vhs_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [vhs_pkg::CFG_DATA_W-1:0]   cfg_data,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic signed [15:0]               vel_x,
  input  logic signed [15:0]               vel_y,
  input  logic signed [15:0]               vel_z,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic [5:0]                       pos_x,
  output logic [5:0]                       pos_y,
  output logic [11:0]                      pos_z,
  output logic signed [31:0]               curl_x,
  output logic signed [31:0]               curl_y,
  output logic signed [31:0]               curl_z,
  output logic [31:0]                      curl_magnitude,
  output logic signed [47:0]               helicity,
  output logic                             last_voxel
);

  vhs_pkg::cfg_t cfg;
  vhs_pkg::cmd_t cmd;
  vhs_pkg::sts_t sts;

  // Register writes are always taken
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.size_x <= vhs_pkg::SIZE_XY_RST;
      cfg.size_y <= vhs_pkg::SIZE_XY_RST;
      cfg.size_z <= vhs_pkg::SIZE_Z_RST;
      cfg.coef_x <= vhs_pkg::COEF_RST;
      cfg.coef_y <= vhs_pkg::COEF_RST;
      cfg.coef_z <= vhs_pkg::COEF_RST;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        vhs_pkg::REG_SIZE_X: cfg.size_x <= cfg_data[6:0];
        vhs_pkg::REG_SIZE_Y: cfg.size_y <= cfg_data[6:0];
        vhs_pkg::REG_SIZE_Z: cfg.size_z <= cfg_data[11:0];
        vhs_pkg::REG_COEF_X: cfg.coef_x <= cfg_data;
        vhs_pkg::REG_COEF_Y: cfg.coef_y <= cfg_data;
        vhs_pkg::REG_COEF_Z: cfg.coef_z <= cfg_data;
        default: cfg <= cfg;  // drop writes to unused indexes
      endcase
    end
  end

  // Sequencer
  vhs_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // Counters, plane memory, arithmetic and output register
  vhs_datapath #(
    .MAX_X    (MAX_X),
    .MAX_Y    (MAX_Y),
    .VEL_BITS (VEL_BITS)
  ) u_dp (
    .clk            (clk),
    .rst            (rst),
    .cfg            (cfg),
    .cmd            (cmd),
    .sts            (sts),
    .vel_x          (vel_x),
    .vel_y          (vel_y),
    .vel_z          (vel_z),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .pos_x          (pos_x),
    .pos_y          (pos_y),
    .pos_z          (pos_z),
    .curl_x         (curl_x),
    .curl_y         (curl_y),
    .curl_z         (curl_z),
    .curl_magnitude (curl_magnitude),
    .helicity       (helicity),
    .last_voxel     (last_voxel)
  );

endmodule

FILE: verif/vorticity_helicity_stencil_tb.sv
// ----------------------------------------------------------------------------
// vorticity_helicity_stencil_tb
// Streams velocity volumes through the stencil at several sizes and
// coefficient settings, predicts curl, magnitude and helicity in-bench, and
// checks every reported voxel while both sides idle and stall at random.
// ----------------------------------------------------------------------------
module vorticity_helicity_stencil_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int PLANE_W = 64 * 64;
  localparam int CYCLE_LIMIT = 3000000;

  typedef struct packed {
    logic signed [15:0] vx;
    logic signed [15:0] vy;
    logic signed [15:0] vz;
  } voxel_t;

  typedef struct {
    logic [5:0]         px;
    logic [5:0]         py;
    logic [11:0]        pz;
    logic signed [31:0] cx;
    logic signed [31:0] cy;
    logic signed [31:0] cz;
    logic [31:0]        mag;
    logic signed [47:0] hel;
    logic               last;
  } curl_result_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [vhs_pkg::CFG_IDX_W-1:0] cfg_index = vhs_pkg::REG_SIZE_X;
  logic [vhs_pkg::CFG_DATA_W-1:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic signed [15:0] vel_x = '0;
  logic signed [15:0] vel_y = '0;
  logic signed [15:0] vel_z = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [5:0] pos_x, pos_y;
  logic [11:0] pos_z;
  logic signed [31:0] curl_x, curl_y, curl_z;
  logic [31:0] curl_magnitude;
  logic signed [47:0] helicity;
  logic last_voxel;

  vorticity_helicity_stencil u_top (.*);

  // Voxels waiting to be offered and voxel results waiting to come out
  voxel_t       voxel_queue[$];
  curl_result_t curl_expected[$];

  // In-bench copy of the block's state and configuration
  logic signed [15:0] plane_mem[3][2*PLANE_W];
  int unsigned col_n, row_n, plane_n;
  logic [6:0]  size_x_r, size_y_r;
  logic [11:0] size_z_r;
  logic [15:0] coef_x_r, coef_y_r, coef_z_r;

  int error_count = 0;
  int accepted_n = 0;
  int results_n = 0;
  int unsigned cycle_n = 0;
  int hold_cycles = 0;
  bit hold_done = 0;

  initial begin
    forever #1 clk = ~clk;
  end

  // Run-wide timeout
  always @(posedge clk) begin
    cycle_n <= cycle_n + 1;
    if (cycle_n > CYCLE_LIMIT) begin
      $display("vorticity_helicity_stencil_tb: errors");
      $finish;
    end
  end

  task automatic report(string field, longint got, longint want);
    error_count++;
    $display("mismatch on %s at result %0d: got %0d, want %0d", field, results_n, got, want);
  endtask

  function automatic int unsigned clamp_size(int unsigned v, int unsigned hi);
    if (v < 3) return 3;
    if (v > hi) return hi;
    return v;
  endfunction

  function automatic longint sat_to(longint v, int bits);
    longint hi, lo;
    hi = (longint'(1) <<< (bits - 1)) - 1;
    lo = -hi - 1;
    if (v > hi) return hi;
    if (v < lo) return lo;
    return v;
  endfunction

  function automatic longint unsigned int_sqrt(longint unsigned n);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > n) b >>= 2;
    while (b != 0) begin
      if (n >= r + b) begin
        n -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  function automatic longint plane_at(int c, int unsigned par, int unsigned x, int unsigned y);
    return plane_mem[c][(par & 1) * PLANE_W + (y % 64) * 64 + (x % 64)];
  endfunction

  // Difference pair scaled by Q8.8 coefficients, floored and saturated
  function automatic longint scaled_curl(longint da, longint ca, longint db, longint cb);
    return sat_to((da * ca - db * cb) >>> 8, 32);
  endfunction

  // Take one voxel into the in-bench state, queue a result if it completes one
  task automatic curl_predict(voxel_t vox);
    int unsigned sx, sy, sz, x, y, z, pc;
    longint v[3], dxv[3], dyv[3], dzv[3], vc[3], w[3], hel;
    longint unsigned sq, m;
    curl_result_t r;
    sx = clamp_size(size_x_r, 64);
    sy = clamp_size(size_y_r, 64);
    sz = clamp_size(size_z_r, 4095);
    x = col_n % 64;
    y = row_n % 64;
    z = plane_n;
    v[0] = vox.vx;
    v[1] = vox.vy;
    v[2] = vox.vz;
    if (z >= 2 && z <= sz - 1 && x >= 1 && x + 2 <= sx && y >= 1 && y + 2 <= sy) begin
      pc = z - 1;
      for (int c = 0; c < 3; c++) begin
        dxv[c] = plane_at(c, pc, x + 1, y) - plane_at(c, pc, x - 1, y);
        dyv[c] = plane_at(c, pc, x, y + 1) - plane_at(c, pc, x, y - 1);
        // slot of plane z-2 is the slot that plane z now arrives into
        dzv[c] = v[c] - plane_at(c, z, x, y);
        vc[c] = plane_at(c, pc, x, y);
      end
      w[0] = scaled_curl(dyv[2], coef_y_r, dzv[1], coef_z_r);
      w[1] = scaled_curl(dzv[0], coef_z_r, dxv[2], coef_x_r);
      w[2] = scaled_curl(dxv[1], coef_x_r, dyv[0], coef_y_r);
      sq = 0;
      hel = 0;
      for (int c = 0; c < 3; c++) begin
        sq += longint'(w[c] * w[c]);
        hel += vc[c] * w[c];
      end
      m = int_sqrt(sq);
      r.px = x[5:0];
      r.py = y[5:0];
      r.pz = pc[11:0];
      r.cx = w[0][31:0];
      r.cy = w[1][31:0];
      r.cz = w[2][31:0];
      r.mag = (m > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : m[31:0];
      r.hel = 48'(sat_to(hel >>> 8, 48));
      r.last = (x + 2 == sx && y + 2 == sy && z == sz - 1);
      curl_expected.insert(curl_expected.size(), r);
    end
    for (int c = 0; c < 3; c++) plane_mem[c][(z & 1) * PLANE_W + y * 64 + x] = 16'(v[c]);
    col_n++;
    if (col_n >= sx) begin
      col_n = 0;
      row_n++;
      if (row_n >= sy) begin
        row_n = 0;
        plane_n++;
        if (plane_n >= sz) plane_n = 0;
      end
    end
  endtask

  // Idling profile by progress: sender 27 / receiver 77, then swapped, then none
  function automatic int send_idle_pct();
    if (accepted_n < 195) return 27;
    if (accepted_n < 390) return 77;
    return 0;
  endfunction

  function automatic int recv_idle_pct();
    if (accepted_n < 195) return 77;
    if (accepted_n < 390) return 27;
    return 0;
  endfunction

  // Driver: advance the voxel stream, hold valid and payload until taken
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        curl_predict('{vx: vel_x, vy: vel_y, vz: vel_z});
        accepted_n++;
      end
      if (!in_valid || in_ready) begin
        if (voxel_queue.size() != 0 && $urandom_range(99) >= send_idle_pct()) begin
          voxel_t nv;
          nv = voxel_queue.pop_front();
          vel_x <= nv.vx;
          vel_y <= nv.vy;
          vel_z <= nv.vz;
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Long receiver hold, counted on its own so the block backs up its input
  always @(posedge clk) begin
    if (rst) begin
      hold_cycles <= 0;
    end else if (!hold_done && results_n >= 20) begin
      hold_cycles <= hold_cycles + 1;
      if (hold_cycles == 599) hold_done <= 1'b1;
    end
  end

  // Monitor: compare each result with the oldest expectation
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (curl_expected.size() == 0) begin
          report("unexpected result", 1, 0);
        end else begin
          curl_result_t e;
          e = curl_expected.pop_front();
          if (pos_x !== e.px) report("pos_x", pos_x, e.px);
          if (pos_y !== e.py) report("pos_y", pos_y, e.py);
          if (pos_z !== e.pz) report("pos_z", pos_z, e.pz);
          if (curl_x !== e.cx) report("curl_x", curl_x, e.cx);
          if (curl_y !== e.cy) report("curl_y", curl_y, e.cy);
          if (curl_z !== e.cz) report("curl_z", curl_z, e.cz);
          if (curl_magnitude !== e.mag) report("curl_magnitude", curl_magnitude, e.mag);
          if (helicity !== e.hel) report("helicity", helicity, e.hel);
          if (last_voxel !== e.last) report("last_voxel", last_voxel, e.last);
        end
        results_n++;
      end
      if (!hold_done && results_n >= 20) begin
        out_ready <= 1'b0;
      end else begin
        out_ready <= ($urandom_range(99) >= recv_idle_pct());
      end
    end
  end

  task automatic cfg_write(logic [vhs_pkg::CFG_IDX_W-1:0] idx, logic [15:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      vhs_pkg::REG_SIZE_X: size_x_r = val[6:0];
      vhs_pkg::REG_SIZE_Y: size_y_r = val[6:0];
      vhs_pkg::REG_SIZE_Z: size_z_r = val[11:0];
      vhs_pkg::REG_COEF_X: coef_x_r = val;
      vhs_pkg::REG_COEF_Y: coef_y_r = val;
      vhs_pkg::REG_COEF_Z: coef_z_r = val;
      default: ;
    endcase
  endtask

  task automatic set_all(int sx, int sy, int sz, int cx, int cy, int cz);
    cfg_write(vhs_pkg::REG_SIZE_X, 16'(sx));
    cfg_write(vhs_pkg::REG_SIZE_Y, 16'(sy));
    cfg_write(vhs_pkg::REG_SIZE_Z, 16'(sz));
    cfg_write(vhs_pkg::REG_COEF_X, 16'(cx));
    cfg_write(vhs_pkg::REG_COEF_Y, 16'(cy));
    cfg_write(vhs_pkg::REG_COEF_Z, 16'(cz));
  endtask

  function automatic logic signed [15:0] rand_vel();
    case ($urandom_range(7))
      0: return 16'sh7FFF;
      1: return 16'sh8000;
      default: return 16'($urandom());
    endcase
  endfunction

  // Queue a number of random voxels
  task automatic add_voxels(int n);
    for (int i = 0; i < n; i++)
      voxel_queue.insert(voxel_queue.size(), '{vx: rand_vel(), vy: rand_vel(), vz: rand_vel()});
  endtask

  // Queue random voxels for a number of whole planes
  task automatic add_planes(int sx, int sy, int planes);
    add_voxels(sx * sy * planes);
  endtask

  // Drain: wait until nothing is offered, nothing is expected, then let the
  // block finish any voxel that gives no result
  task automatic drain();
    while (voxel_queue.size() != 0 || in_valid || curl_expected.size() != 0)
      @(posedge clk);
    repeat (80) @(posedge clk);
  endtask

  function automatic logic signed [15:0] ramp(int c);
    if (c == 0) return 16'sh8000;
    if (c == 1) return 16'sh7FFF;
    return 16'sh7FFF;
  endfunction

  initial begin
    col_n = 0;
    row_n = 0;
    plane_n = 0;
    size_x_r = vhs_pkg::SIZE_XY_RST;
    size_y_r = vhs_pkg::SIZE_XY_RST;
    size_z_r = vhs_pkg::SIZE_Z_RST;
    coef_x_r = vhs_pkg::COEF_RST;
    coef_y_r = vhs_pkg::COEF_RST;
    coef_z_r = vhs_pkg::COEF_RST;
    for (int c = 0; c < 3; c++)
      for (int i = 0; i < 2 * PLANE_W; i++) plane_mem[c][i] = '0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // Smallest volume, largest coefficients: each component ramps across one
    // axis so its difference along that axis is full scale and the curl saturates
    set_all(3, 3, 3, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    for (int z = 0; z < 3; z++)
      for (int y = 0; y < 3; y++)
        for (int x = 0; x < 3; x++)
          voxel_queue.insert(voxel_queue.size(), '{vx: ramp(z), vy: ramp(x), vz: ramp(y)});
    drain();

    // Below-minimum sizes clamp; zero coefficient on x
    set_all(0, 5, 0, 0, 16'hFFFF, 1280);
    add_planes(3, 5, 3);
    drain();

    // Above-maximum width clamps, deepest volume: stream two planes and the
    // first rows of the third, no write follows
    set_all(127, 3, 4095, $urandom_range(65535), $urandom_range(65535),
            $urandom_range(65535));
    add_planes(64, 3, 2);
    add_voxels(64 * 2);
    drain();

    if (error_count == 0) begin
      $display("vorticity_helicity_stencil_tb: clean");
    end else begin
      $display("vorticity_helicity_stencil_tb: errors");
    end
    $finish;
  end

endmodule

FILE: files.f
hw/rtl/vhs_pkg.sv
hw/rtl/vhs_ctrl.sv
hw/rtl/vhs_datapath.sv
hw/rtl/vorticity_helicity_stencil.sv
verif/vorticity_helicity_stencil_tb.sv
